// ----- rtl/spq_pkg.sv -----
package spq_pkg;

    localparam int unsigned QueueDepth  = 16;
    localparam int unsigned PayloadBits = 16;
    localparam int unsigned PriBits     = 8;
    localparam int unsigned OccBits     = 5;

    typedef enum logic {
        CMD_PUSH = 1'b0,
        CMD_POP  = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        ST_PUSHED = 2'd0,
        ST_POPPED = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_FULL   = 2'd3
    } t_status;

    typedef struct packed {
        logic               push;
        logic               pop;
        logic [PriBits-1:0] pri;
    } t_cell_ctrl;

endpackage

// ----- rtl/spq_if.sv -----
interface spq_in_if #(
    parameter int unsigned PAYLOAD_BITS = spq_pkg::PayloadBits
);
    logic                      valid;
    logic                      ready;
    logic                      command;
    logic [spq_pkg::PriBits-1:0] priority_in;
    logic [PAYLOAD_BITS-1:0]   payload_in;

    modport source (output valid, command, priority_in, payload_in, input ready);
    modport sink   (input valid, command, priority_in, payload_in, output ready);
endinterface

interface spq_out_if #(
    parameter int unsigned PAYLOAD_BITS = spq_pkg::PayloadBits
);
    logic                        valid;
    logic                        ready;
    logic [1:0]                  status;
    logic [spq_pkg::PriBits-1:0] priority_out;
    logic [PAYLOAD_BITS-1:0]     payload_out;
    logic [spq_pkg::OccBits-1:0] occupancy;

    modport source (output valid, status, priority_out, payload_out, occupancy,
                    input ready);
    modport sink   (input valid, status, priority_out, payload_out, occupancy,
                    output ready);
endinterface

// ----- rtl/spq_cell.sv -----
module spq_cell #(
    parameter int unsigned PAYLOAD_BITS = spq_pkg::PayloadBits
) (
    input  logic                        i_clk,
    input  spq_pkg::t_cell_ctrl         i_ctrl,
    input  logic [PAYLOAD_BITS-1:0]     i_new_pay,
    input  logic                        i_occupied,
    input  logic                        i_left_ge,
    input  logic [spq_pkg::PriBits-1:0] i_left_pri,
    input  logic [PAYLOAD_BITS-1:0]     i_left_pay,
    input  logic [spq_pkg::PriBits-1:0] i_right_pri,
    input  logic [PAYLOAD_BITS-1:0]     i_right_pay,
    output logic                        o_ge,
    output logic [spq_pkg::PriBits-1:0] o_pri,
    output logic [PAYLOAD_BITS-1:0]     o_pay
);

    logic [spq_pkg::PriBits-1:0] r_pri, n_pri;
    logic [PAYLOAD_BITS-1:0]     r_pay, n_pay;

    assign o_ge  = i_occupied && (r_pri >= i_ctrl.pri);
    assign o_pri = r_pri;
    assign o_pay = r_pay;

    always_comb begin
        n_pri = r_pri;
        n_pay = r_pay;
        if (i_ctrl.push && !o_ge) begin
            if (i_left_ge) begin
                n_pri = i_ctrl.pri;
                n_pay = i_new_pay;
            end else begin
                n_pri = i_left_pri;
                n_pay = i_left_pay;
            end
        end else if (i_ctrl.pop) begin
            n_pri = i_right_pri;
            n_pay = i_right_pay;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pri <= n_pri;
        r_pay <= n_pay;
    end

endmodule

// ----- rtl/stable_priority_queue.sv -----
// Result: each input transfer yields a registered result, valid from the cycle after it.
// Throughput: one push or pop transfer per cycle, unless a held result stalls;
// the whole cell row updates in the cycle of the transfer, each cell comparing its priority locally.
// Reset (synchronous, active low) empties the queue and drops any pending
// result; cell contents are not reset and are read only below the count.
module stable_priority_queue #(
    parameter int unsigned QUEUE_DEPTH  = spq_pkg::QueueDepth,
    parameter int unsigned PAYLOAD_BITS = spq_pkg::PayloadBits
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    spq_in_if.sink    i_in,
    spq_out_if.source o_out
);

    localparam int unsigned CntBits = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned PB      = spq_pkg::PriBits;

    logic [CntBits-1:0] r_count, n_count;
    logic               r_valid, n_valid;
    logic [1:0]         r_status, n_status;
    logic [PB-1:0]      r_pri_out, n_pri_out;
    logic [PAYLOAD_BITS-1:0] r_pay_out, n_pay_out;

    logic xfer, push_ok, pop_ok, is_full, is_empty;
    spq_pkg::t_cell_ctrl ctrl;

    logic [QUEUE_DEPTH-1:0]  ge;
    logic [PB-1:0]           c_pri [QUEUE_DEPTH];
    logic [PAYLOAD_BITS-1:0] c_pay [QUEUE_DEPTH];

    assign i_in.ready = !r_valid || o_out.ready;
    assign xfer       = i_in.valid && i_in.ready;
    assign is_full    = (r_count == CntBits'(QUEUE_DEPTH));
    assign is_empty   = (r_count == '0);
    assign push_ok    = xfer && (i_in.command == spq_pkg::CMD_PUSH) && !is_full;
    assign pop_ok     = xfer && (i_in.command == spq_pkg::CMD_POP) && !is_empty;

    assign ctrl.push = push_ok;
    assign ctrl.pop  = pop_ok;
    assign ctrl.pri  = i_in.priority_in;

    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        logic                    left_ge;
        logic [PB-1:0]           left_pri, right_pri;
        logic [PAYLOAD_BITS-1:0] left_pay, right_pay;

        if (g == 0) begin : g_head
            assign left_ge  = 1'b1;
            assign left_pri = i_in.priority_in;
            assign left_pay = i_in.payload_in;
        end else begin : g_mid
            assign left_ge  = ge[g-1];
            assign left_pri = c_pri[g-1];
            assign left_pay = c_pay[g-1];
        end

        if (g == QUEUE_DEPTH - 1) begin : g_tail
            assign right_pri = c_pri[g];
            assign right_pay = c_pay[g];
        end else begin : g_body
            assign right_pri = c_pri[g+1];
            assign right_pay = c_pay[g+1];
        end

        spq_cell #(
            .PAYLOAD_BITS (PAYLOAD_BITS)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctrl      (ctrl),
            .i_new_pay   (i_in.payload_in),
            .i_occupied  (CntBits'(g) < r_count),
            .i_left_ge   (left_ge),
            .i_left_pri  (left_pri),
            .i_left_pay  (left_pay),
            .i_right_pri (right_pri),
            .i_right_pay (right_pay),
            .o_ge        (ge[g]),
            .o_pri       (c_pri[g]),
            .o_pay       (c_pay[g])
        );
    end

    always_comb begin
        n_count   = r_count;
        n_valid   = r_valid && !o_out.ready;
        n_status  = r_status;
        n_pri_out = r_pri_out;
        n_pay_out = r_pay_out;
        if (xfer) begin
            n_valid   = 1'b1;
            n_pri_out = '0;
            n_pay_out = '0;
            if (i_in.command == spq_pkg::CMD_PUSH) begin
                if (is_full) begin
                    n_status = spq_pkg::ST_FULL;
                end else begin
                    n_status = spq_pkg::ST_PUSHED;
                    n_count  = r_count + 1'b1;
                end
            end else begin
                if (is_empty) begin
                    n_status = spq_pkg::ST_EMPTY;
                end else begin
                    n_status  = spq_pkg::ST_POPPED;
                    n_count   = r_count - 1'b1;
                    n_pri_out = c_pri[0];
                    n_pay_out = c_pay[0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            r_valid <= n_valid;
        end
        r_status  <= n_status;
        r_pri_out <= n_pri_out;
        r_pay_out <= n_pay_out;
    end

    // result occupancy is the post-transfer count, kept in the low bits
    logic [CntBits-1:0] r_occ;
    always_ff @(posedge i_clk) begin
        if (xfer) begin
            r_occ <= n_count;
        end
    end

    assign o_out.valid        = r_valid;
    assign o_out.status       = r_status;
    assign o_out.priority_out = r_pri_out;
    assign o_out.payload_out  = r_pay_out;
    if (CntBits >= spq_pkg::OccBits) begin : g_occ_trunc
        assign o_out.occupancy = r_occ[spq_pkg::OccBits-1:0];
    end else begin : g_occ_ext
        assign o_out.occupancy = spq_pkg::OccBits'(r_occ);
    end

endmodule

// ----- rtl/spq_checker.sv -----
module spq_checker #(
    parameter int unsigned QUEUE_DEPTH  = spq_pkg::QueueDepth,
    parameter int unsigned PAYLOAD_BITS = spq_pkg::PayloadBits
) (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic [1:0]                  i_status,
    input logic [spq_pkg::PriBits-1:0] i_priority_out,
    input logic [PAYLOAD_BITS-1:0]     i_payload_out,
    input logic [spq_pkg::OccBits-1:0] i_occupancy
);

    localparam logic [spq_pkg::OccBits-1:0] FullOcc = spq_pkg::OccBits'(QUEUE_DEPTH);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_status)
            && $stable(i_payload_out) && $stable(i_occupancy))
        else $error("result changed while stalled");

    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status == spq_pkg::ST_EMPTY) |->
            (i_occupancy == '0) && (i_priority_out == '0) && (i_payload_out == '0))
        else $error("empty result with nonzero fields");

    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status == spq_pkg::ST_FULL) |->
            (i_occupancy == FullOcc) && (i_priority_out == '0) && (i_payload_out == '0))
        else $error("full result with wrong fields");

    a_pushed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status == spq_pkg::ST_PUSHED) |->
            (i_priority_out == '0) && (i_payload_out == '0) && (i_occupancy != '0))
        else $error("push result with wrong fields");

endmodule

bind stable_priority_queue spq_checker #(
    .QUEUE_DEPTH  (QUEUE_DEPTH),
    .PAYLOAD_BITS (PAYLOAD_BITS)
) u_spq_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_status       (o_out.status),
    .i_priority_out (o_out.priority_out),
    .i_payload_out  (o_out.payload_out),
    .i_occupancy    (o_out.occupancy)
);

// ----- bench/tb_stable_priority_queue.sv -----
`timescale 1ns / 100ps

module tb_stable_priority_queue;
    import spq_pkg::*;

    localparam int unsigned RandomItems = 1750;
    localparam int unsigned HoldCycles  = 100;
    localparam int unsigned CycleLimit  = 400000;
    localparam int unsigned TailCycles  = 8;

    typedef struct {
        t_status                status;
        logic [PriBits-1:0]     pri;
        logic [PayloadBits-1:0] payload;
        logic [OccBits-1:0]     occ;
    } t_pq_result;

    class pq_mirror;
        logic [PriBits-1:0]     slot_pri [QueueDepth];
        logic [PayloadBits-1:0] slot_payload [QueueDepth];
        int unsigned            fill;
        int unsigned            mismatches;
        t_pq_result             awaited_results[$];

        function new();
            fill       = 0;
            mismatches = 0;
        endfunction

        function int unsigned outstanding();
            return awaited_results.size();
        endfunction

        function void note_request(t_cmd cmd, logic [PriBits-1:0] pri,
                                   logic [PayloadBits-1:0] payload);
            t_pq_result  res;
            int unsigned pos;
            int          k;
            res.status  = ST_PUSHED;
            res.pri     = '0;
            res.payload = '0;
            if (cmd == CMD_PUSH) begin
                if (fill >= QueueDepth) begin
                    res.status = ST_FULL;
                end else begin
                    pos = 0;
                    while (pos < fill && slot_pri[pos] >= pri) pos++;
                    for (k = int'(fill); k > int'(pos); k--) begin
                        slot_pri[k]     = slot_pri[k-1];
                        slot_payload[k] = slot_payload[k-1];
                    end
                    slot_pri[pos]     = pri;
                    slot_payload[pos] = payload;
                    fill++;
                end
            end else if (fill == 0) begin
                res.status = ST_EMPTY;
            end else begin
                res.status  = ST_POPPED;
                res.pri     = slot_pri[0];
                res.payload = slot_payload[0];
                for (k = 1; k < int'(fill); k++) begin
                    slot_pri[k-1]     = slot_pri[k];
                    slot_payload[k-1] = slot_payload[k];
                end
                fill--;
            end
            res.occ = OccBits'(fill);
            awaited_results.push_back(res);
        endfunction

        function void check_result(logic [1:0] status, logic [PriBits-1:0] pri,
                                   logic [PayloadBits-1:0] payload,
                                   logic [OccBits-1:0] occ);
            t_pq_result exp;
            if (awaited_results.size() == 0) begin
                $error("unexpected result transfer: status %0d", status);
                mismatches++;
                return;
            end
            exp = awaited_results.pop_front();
            if (status !== exp.status) begin
                $error("status: expected %0d, actual %0d", exp.status, status);
                mismatches++;
            end
            if (pri !== exp.pri) begin
                $error("priority_out: expected %0d, actual %0d", exp.pri, pri);
                mismatches++;
            end
            if (payload !== exp.payload) begin
                $error("payload_out: expected %h, actual %h", exp.payload, payload);
                mismatches++;
            end
            if (occ !== exp.occ) begin
                $error("occupancy: expected %0d, actual %0d", exp.occ, occ);
                mismatches++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic hold_req;

    spq_in_if  in_ch ();
    spq_out_if out_ch ();

    pq_mirror tracker;

    stable_priority_queue dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready) begin
                tracker.note_request(t_cmd'(in_ch.command), in_ch.priority_in,
                                     in_ch.payload_in);
            end
            if (out_ch.valid && out_ch.ready) begin
                tracker.check_result(out_ch.status, out_ch.priority_out,
                                     out_ch.payload_out, out_ch.occupancy);
            end
        end
    end

    initial begin
        int unsigned rx_mode;
        int unsigned rx_left;
        int unsigned rx_phase;
        rx_mode  = 0;
        rx_left  = 0;
        rx_phase = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                out_ch.ready <= 1'b0;
                repeat (HoldCycles) @(posedge i_clk);
            end else begin
                if (rx_left == 0) begin
                    rx_mode = $urandom_range(0, 3);
                    rx_left = $urandom_range(50, 300);
                end
                rx_left--;
                rx_phase++;
                case (rx_mode)
                    0: begin
                        out_ch.ready <= 1'b1;
                    end
                    1: begin
                        out_ch.ready <= 1'($urandom_range(0, 1));
                    end
                    2: begin
                        out_ch.ready <= ($urandom_range(0, 3) == 0);
                    end
                    default: begin
                        out_ch.ready <= (rx_phase % 5) < 3;
                    end
                endcase
            end
        end
    end

    initial begin
        repeat (CycleLimit) @(posedge i_clk);
        $display("FAIL stable_priority_queue");
        $finish;
    end

    task automatic send_request(input t_cmd cmd, input logic [PriBits-1:0] pri,
                                input logic [PayloadBits-1:0] payload);
        in_ch.valid       <= 1'b1;
        in_ch.command     <= cmd;
        in_ch.priority_in <= pri;
        in_ch.payload_in  <= payload;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    task automatic pause_sender(input int unsigned cycles);
        in_ch.valid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic drain_results();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (tracker.outstanding() != 0);
    endtask

    function automatic logic [PriBits-1:0] pick_priority();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2, 3, 4: return PriBits'($urandom_range(0, 3) * 64);
            default: return PriBits'($urandom_range(0, 255));
        endcase
    endfunction

    initial begin
        int unsigned sent;
        int unsigned push_pct;
        int unsigned phase_len;
        int unsigned burst_left;
        int unsigned gap;
        bit          no_gaps;
        t_cmd        cmd;

        tracker  = new();
        hold_req = 1'b0;
        i_rst_n           <= 1'b0;
        in_ch.valid       <= 1'b0;
        in_ch.command     <= CMD_PUSH;
        in_ch.priority_in <= '0;
        in_ch.payload_in  <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty pop, ties at the extremes, fill to the brim, refused push
        send_request(CMD_POP, 8'h00, 16'h0000);
        send_request(CMD_PUSH, 8'h80, 16'h0001);
        send_request(CMD_PUSH, 8'h80, 16'h0002);
        send_request(CMD_PUSH, 8'hFF, 16'hFFFF);
        send_request(CMD_PUSH, 8'h00, 16'h0000);
        send_request(CMD_PUSH, 8'h80, 16'h0003);
        send_request(CMD_PUSH, 8'hFF, 16'h1234);
        send_request(CMD_PUSH, 8'h00, 16'hAAAA);
        for (int k = 0; k < 9; k++) begin
            send_request(CMD_PUSH, PriBits'(k * 31), 16'h5555 ^ 16'(k));
        end
        send_request(CMD_PUSH, 8'hFF, 16'hBEEF);
        repeat (4) send_request(CMD_POP, 8'hFF, 16'hFFFF);

        sent       = 0;
        burst_left = 0;
        while (sent < RandomItems) begin
            case ($urandom_range(0, 3))
                0:       push_pct = 80;
                1:       push_pct = 20;
                default: push_pct = 50;
            endcase
            phase_len = $urandom_range(20, 60);
            no_gaps   = ($urandom_range(0, 3) == 0);
            if (sent == 0 || $urandom_range(0, 11) == 0) begin
                drain_results();
            end
            if ((sent >= 300 && sent < 360) || $urandom_range(0, 15) == 0) begin
                hold_req  = 1'b1;
                push_pct  = 80;
                no_gaps   = 1'b1;
            end
            repeat (phase_len) begin
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 24);
                    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    if (!no_gaps && gap != 0) pause_sender(gap);
                end
                cmd = ($urandom_range(1, 100) <= push_pct) ? CMD_PUSH : CMD_POP;
                send_request(cmd, pick_priority(), PayloadBits'($urandom));
                burst_left--;
                sent++;
            end
        end

        drain_results();
        repeat (TailCycles) @(posedge i_clk);
        if (tracker.mismatches == 0 && tracker.outstanding() == 0) begin
            $display("PASS stable_priority_queue");
        end else begin
            $display("FAIL stable_priority_queue");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/spq_pkg.sv
rtl/spq_if.sv
rtl/spq_cell.sv
rtl/stable_priority_queue.sv
rtl/spq_checker.sv
bench/tb_stable_priority_queue.sv
